// ===== rtl/core/cat_text_stream_filter_assert.svh =====
// Assertion macros for the cat text stream filter checker.
// Included by the checker module; it depends on nothing else.
`ifndef CAT_TEXT_STREAM_FILTER_ASSERT_SVH
`define CAT_TEXT_STREAM_FILTER_ASSERT_SVH

// Checks a property on the rising clock edge while the active-low reset is released.
`define CAT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cat filter check failed");

// Checks a property on every rising clock edge, reset included.
`define CAT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cat filter check failed");

`endif

// ===== rtl/core/cat_pkg.sv =====
// Shared types, constants and character codes of the cat text stream filter.
// Depends on nothing; used by every RTL module of the block.
`default_nettype none

package cat_pkg;

  localparam int unsigned NumberDigits = 6;
  localparam int unsigned BcdWidth     = 4 * NumberDigits;
  localparam int unsigned MaxResults   = NumberDigits + 5;
  localparam int unsigned IdxWidth     = $clog2(MaxResults + 1);
  localparam int unsigned DigIdxWidth  = (NumberDigits > 1) ? $clog2(NumberDigits) : 1;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QPtrWidth    = $clog2(QueueDepth);
  localparam int unsigned QCntWidth    = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxWidth  = 3;

  localparam logic [CfgIdxWidth-1:0] RegNumberAll      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegNumberNonblank = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegSqueezeBlank   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegShowEnds       = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegShowTabs       = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegShowNonprint   = 3'd5;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [3:0] ChZeroHi  = 4'h3;
  localparam logic [7:0] ChQuest   = 8'h3F;
  localparam logic [7:0] ChCapI    = 8'h49;
  localparam logic [7:0] ChCapM    = 8'h4D;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] CtrlShift = 8'h40;
  localparam logic [6:0] CodeDel   = 7'h7F;
  localparam logic [6:0] CodeSpace = 7'h20;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // One accepted request that produces output: optional line number, then 1..4 bytes.
  typedef struct packed {
    logic                has_num;
    logic [BcdWidth-1:0] bcd;
    logic [3:0][7:0]     chars;
    logic [2:0]          nchars;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/cat_front.sv =====
// Front end: accepts input bytes, tracks line state and the BCD line counter,
// and turns each request but a squeezed blank line into a queue job. Depends on cat_pkg.
`default_nettype none

module cat_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cat_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output cat_pkg::job_t      job_o
);

  logic                         at_start_q, at_start_d;
  logic                         prev_blank_q, prev_blank_d;
  logic [cat_pkg::BcdWidth-1:0] bcd_q, bcd_d, bcd_inc;
  logic                         accept;
  logic                         is_nl;
  logic                         drop;
  logic                         use_num;
  logic [6:0]                   low;
  logic [7:0]                   b0, b1;
  logic [2:0]                   bn;
  logic                         carry;
  logic                         all_nines;
  logic [3:0]                   dig;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = (in_byte_i == cat_pkg::ChNewline);
  assign low        = in_byte_i[6:0];

  always_comb begin
    carry     = 1'b1;
    all_nines = 1'b1;
    bcd_inc   = bcd_q;
    for (int i = 0; i < int'(cat_pkg::NumberDigits); i++) begin
      dig = bcd_q[4*i +: 4];
      if (dig != 4'd9) begin
        all_nines = 1'b0;
      end
      if (carry) begin
        if (dig == 4'd9) begin
          bcd_inc[4*i +: 4] = 4'd0;
        end else begin
          bcd_inc[4*i +: 4] = dig + 4'd1;
          carry             = 1'b0;
        end
      end
    end
    if (all_nines) begin
      bcd_inc = bcd_q;
    end
  end

  always_comb begin
    if (low < cat_pkg::CodeSpace) begin
      b0 = cat_pkg::ChCaret;
      b1 = {1'b0, low} + cat_pkg::CtrlShift;
      bn = 3'd2;
    end else if (low == cat_pkg::CodeDel) begin
      b0 = cat_pkg::ChCaret;
      b1 = cat_pkg::ChQuest;
      bn = 3'd2;
    end else begin
      b0 = {1'b0, low};
      b1 = 8'h00;
      bn = 3'd1;
    end
  end

  always_comb begin
    at_start_d   = at_start_q;
    prev_blank_d = prev_blank_q;
    drop         = 1'b0;
    use_num      = 1'b0;
    job_o.chars  = '0;
    job_o.nchars = 3'd1;
    if (is_nl) begin
      if (at_start_q) begin
        if (cfg_i.squeeze_blank && prev_blank_q) begin
          drop = 1'b1;
        end
        use_num      = cfg_i.number_all && !cfg_i.number_nonblank;
        prev_blank_d = 1'b1;
      end else begin
        prev_blank_d = 1'b0;
      end
      at_start_d = 1'b1;
      if (cfg_i.show_ends) begin
        job_o.chars[0] = cat_pkg::ChDollar;
        job_o.chars[1] = cat_pkg::ChNewline;
        job_o.nchars   = 3'd2;
      end else begin
        job_o.chars[0] = cat_pkg::ChNewline;
      end
    end else begin
      if (at_start_q) begin
        use_num      = cfg_i.number_all || cfg_i.number_nonblank;
        prev_blank_d = 1'b0;
        at_start_d   = 1'b0;
      end
      if (in_byte_i == cat_pkg::ChTab && cfg_i.show_tabs) begin
        job_o.chars[0] = cat_pkg::ChCaret;
        job_o.chars[1] = cat_pkg::ChCapI;
        job_o.nchars   = 3'd2;
      end else if (!cfg_i.show_nonprinting || in_byte_i == cat_pkg::ChTab) begin
        job_o.chars[0] = in_byte_i;
      end else if (in_byte_i[7]) begin
        job_o.chars[0] = cat_pkg::ChCapM;
        job_o.chars[1] = cat_pkg::ChDash;
        job_o.chars[2] = b0;
        job_o.chars[3] = b1;
        job_o.nchars   = 3'd2 + bn;
      end else begin
        job_o.chars[0] = b0;
        job_o.chars[1] = b1;
        job_o.nchars   = bn;
      end
    end
    if (drop) begin
      at_start_d   = at_start_q;
      prev_blank_d = prev_blank_q;
      use_num      = 1'b0;
    end
    job_o.has_num = use_num;
    job_o.bcd     = bcd_q;
  end

  assign push_o        = accept && !drop;
  assign bcd_d         = use_num ? bcd_inc : bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q   <= 1'b1;
      prev_blank_q <= 1'b0;
      bcd_q        <= cat_pkg::BcdWidth'(1);
    end else if (accept) begin
      at_start_q   <= at_start_d;
      prev_blank_q <= prev_blank_d;
      bcd_q        <= bcd_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cat_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on cat_pkg for the job type and the depth.
`default_nettype none

module cat_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cat_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output cat_pkg::job_t      job_o
);

  cat_pkg::job_t                 entries_q [cat_pkg::QueueDepth];
  logic [cat_pkg::QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [cat_pkg::QCntWidth-1:0] cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == cat_pkg::QCntWidth'(cat_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entries_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cat_back.sv =====
// Back end: walks the head job byte by byte into the output register.
// Depends on cat_pkg for the job type and character codes.
`default_nettype none

module cat_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cat_pkg::job_t job_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  logic [cat_pkg::IdxWidth-1:0] idx_q, idx_d;
  logic [cat_pkg::IdxWidth-1:0] offset, total, rel;
  logic [7:0]                   digits [cat_pkg::NumberDigits];
  logic [7:0]                   cur_byte;
  logic                         cur_last;
  logic                         lead;
  logic [3:0]                   dig;
  logic                         advance, load;
  logic                         valid_q, valid_d;
  logic [7:0]                   byte_q;
  logic                         last_q;

  // Digits in print order, most significant first, with leading zeros as blanks.
  always_comb begin
    lead = 1'b1;
    for (int k = 0; k < int'(cat_pkg::NumberDigits); k++) begin
      dig = job_i.bcd[4*(int'(cat_pkg::NumberDigits) - 1 - k) +: 4];
      if (dig != 4'd0 || k == int'(cat_pkg::NumberDigits) - 1) begin
        lead = 1'b0;
      end
      digits[k] = lead ? cat_pkg::ChSpace : {cat_pkg::ChZeroHi, dig};
    end
  end

  assign offset   = job_i.has_num ? cat_pkg::IdxWidth'(cat_pkg::NumberDigits + 1) : '0;
  assign total    = offset + cat_pkg::IdxWidth'(job_i.nchars);
  assign rel      = idx_q - offset;
  assign cur_last = (idx_q == total - 1'b1);

  always_comb begin
    if (job_i.has_num && idx_q < cat_pkg::IdxWidth'(cat_pkg::NumberDigits)) begin
      cur_byte = digits[idx_q[cat_pkg::DigIdxWidth-1:0]];
    end else if (job_i.has_num && idx_q == cat_pkg::IdxWidth'(cat_pkg::NumberDigits)) begin
      cur_byte = cat_pkg::ChTab;
    end else begin
      cur_byte = job_i.chars[rel[1:0]];
    end
  end

  assign advance = !valid_q || out_ready_i;
  assign load    = advance && !empty_i;
  assign pop_o   = load && cur_last;
  assign valid_d = load || (valid_q && !out_ready_i);
  assign idx_d   = cur_last ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cur_byte;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/cat_text_stream_filter.sv =====
// Top level of the cat text stream filter: configuration registers and the
// front end, job queue and back end. Depends on cat_pkg, cat_front, cat_queue, cat_back.
//
//   channel  direction  tdata fields (low bit up)  tlast        tuser
//   s_axis   in         data_byte[7:0]             end_of_file  -
//   m_axis   out        out_byte[7:0]              last_of_run  -
//   cfg      in         cfg_data_i = register bit 0, cfg_index_i selects the register
//
// The back end sends one output byte per cycle while m_axis_tready is not held low;
// a request produces 1 to 4 bytes for the character, 7 more when a line number leads.
// A squeezed blank line is accepted but produces nothing.
// A four-entry job queue lets input be taken while output is stalled.
// Reset is asynchronous and active low; the line counter restarts at one.
`default_nettype none

module cat_text_stream_filter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // data_byte[7:0]
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // out_byte[7:0]
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_we_i,
  input  wire logic [cat_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic                            cfg_data_i
);

  cat_pkg::cfg_t cfg_q;
  cat_pkg::job_t push_job, head_job;
  logic          push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cat_pkg::RegNumberAll:      cfg_q.number_all       <= cfg_data_i;
        cat_pkg::RegNumberNonblank: cfg_q.number_nonblank  <= cfg_data_i;
        cat_pkg::RegSqueezeBlank:   cfg_q.squeeze_blank    <= cfg_data_i;
        cat_pkg::RegShowEnds:       cfg_q.show_ends        <= cfg_data_i;
        cat_pkg::RegShowTabs:       cfg_q.show_tabs        <= cfg_data_i;
        cat_pkg::RegShowNonprint:   cfg_q.show_nonprinting <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  cat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  cat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cat_checker.sv =====
// Port-level checks of the cat text stream filter, bound to the top level.
// Depends on cat_pkg and the assertion macros in cat_text_stream_filter_assert.svh.
`default_nettype none

`include "cat_text_stream_filter_assert.svh"

module cat_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // A stalled result stays offered.
  `CAT_ASSERT(a_out_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // A stalled result keeps its byte and marker.
  `CAT_ASSERT(a_out_hold_data, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // A raw newline only ever leaves as the final byte of a request.
  `CAT_ASSERT(a_newline_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata == cat_pkg::ChNewline |-> m_axis_tlast)

  // Nothing is offered right after reset is released.
  `CAT_ASSERT_ALWAYS(a_quiet_after_reset, clk_i, $rose(rst_ni) |-> !m_axis_tvalid)

endmodule

bind cat_text_stream_filter cat_checker u_cat_checker (.*);

`default_nettype wire
